### src/sti_pkg.sv
// Shared widths, payload types and codes for the segment/triangle intersection unit.
package sti_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int THRESH_W    = 32;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int CROSS_W     = 2 * DIFF_W + 1;
  localparam int PROD_W      = DIFF_W + CROSS_W;
  localparam int DOT_W       = PROD_W + 2;
  localparam int MAG_W       = (DOT_W > THRESH_W) ? DOT_W : THRESH_W;
  localparam int CFG_IDX_W   = 3;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd168;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_START_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_END_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Z     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DET_THRESHOLD = 3'd6;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [CROSS_W-1:0]     cross_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [DOT_W-1:0]       dot_t;

  typedef enum logic [2:0] {
    REASON_HIT      = 3'd0,
    REASON_PARALLEL = 3'd1,
    REASON_U_OUT    = 3'd2,
    REASON_V_OUT    = 3'd3,
    REASON_T_OUT    = 3'd4
  } reason_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] miss_reason;
  } out_item_t;

endpackage

### src/sti_xprod.sv
// Registered exact cross product of two difference vectors.
module sti_xprod
  import sti_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  diff_t  a [3],
  input  diff_t  b [3],
  output cross_t o [3]
);

  cross_t o_r [3];
  cross_t o_nxt [3];

  always_comb begin
    o_nxt[0] = CROSS_W'(a[1]) * CROSS_W'(b[2]) - CROSS_W'(a[2]) * CROSS_W'(b[1]);
    o_nxt[1] = CROSS_W'(a[2]) * CROSS_W'(b[0]) - CROSS_W'(a[0]) * CROSS_W'(b[2]);
    o_nxt[2] = CROSS_W'(a[0]) * CROSS_W'(b[1]) - CROSS_W'(a[1]) * CROSS_W'(b[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r <= o_nxt;
    end
  end

  assign o = o_r;

endmodule

### src/segment_triangle_intersect_unit.sv
// Top level: pipelined Moller-Trumbore segment versus triangle test.
//
// One triangle enters per clock and passes the stages (differences, cross
// products, dot-product terms, sums, sign fold, tests), each holding one
// item, so a stream runs at one transaction per cycle while out_stall is low.
// A stage whose successor is stalled still takes an item if it is empty, so
// bubbles close up before in_stall rises. The user writes segment endpoints
// and the determinant threshold via the cfg port while no triangle is in
// flight; the block does not enforce it. cfg_ready is always high; indexes
// above six are ignored. All arithmetic is exact: no rounding and no division.
module segment_triangle_intersect_unit
  import sti_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THRESH_W-1:0]  cfg_data
);

  // configuration
  coord_t              seg_s_r [3];
  coord_t              seg_e_r [3];
  logic [THRESH_W-1:0] det_threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        seg_s_r[i] <= '0;
        seg_e_r[i] <= '0;
      end
      det_threshold_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEG_START_X:   seg_s_r[0] <= cfg_data[COORD_WIDTH-1:0];
        REG_SEG_START_Y:   seg_s_r[1] <= cfg_data[COORD_WIDTH-1:0];
        REG_SEG_START_Z:   seg_s_r[2] <= cfg_data[COORD_WIDTH-1:0];
        REG_SEG_END_X:     seg_e_r[0] <= cfg_data[COORD_WIDTH-1:0];
        REG_SEG_END_Y:     seg_e_r[1] <= cfg_data[COORD_WIDTH-1:0];
        REG_SEG_END_Z:     seg_e_r[2] <= cfg_data[COORD_WIDTH-1:0];
        REG_DET_THRESHOLD: det_threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // segment direction, stable while items are in flight
  diff_t dir [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir[i] = DIFF_W'(seg_e_r[i]) - DIFF_W'(seg_s_r[i]);
    end
  end

  // stage enables: a stage loads when empty or when its successor moves
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !out_valid_r || !out_stall;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) out_valid_r <= v5_r;
    end
  end

  // stage 1: edge and offset vectors
  coord_t va [3];
  coord_t vb [3];
  coord_t vc [3];
  diff_t  e1_r [3];
  diff_t  e2_r [3];
  diff_t  s_r  [3];

  assign va[0] = in_data.a_x;
  assign va[1] = in_data.a_y;
  assign va[2] = in_data.a_z;
  assign vb[0] = in_data.b_x;
  assign vb[1] = in_data.b_y;
  assign vb[2] = in_data.b_z;
  assign vc[0] = in_data.c_x;
  assign vc[1] = in_data.c_y;
  assign vc[2] = in_data.c_z;

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= DIFF_W'(vb[i]) - DIFF_W'(va[i]);
        e2_r[i] <= DIFF_W'(vc[i]) - DIFF_W'(va[i]);
        s_r[i]  <= DIFF_W'(seg_s_r[i]) - DIFF_W'(va[i]);
      end
    end
  end

  // stage 2: h = dir x e2, q = s x e1
  cross_t h [3];
  cross_t q [3];
  diff_t  e1_2_r [3];
  diff_t  e2_2_r [3];
  diff_t  s_2_r  [3];

  sti_xprod u_xprod_h (
    .clk (clk),
    .en  (en2),
    .a   (dir),
    .b   (e2_r),
    .o   (h)
  );

  sti_xprod u_xprod_q (
    .clk (clk),
    .en  (en2),
    .a   (s_r),
    .b   (e1_r),
    .o   (q)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      e1_2_r <= e1_r;
      e2_2_r <= e2_r;
      s_2_r  <= s_r;
    end
  end

  // stage 3: dot-product terms
  prod_t pdet_r [3];
  prod_t pnu_r  [3];
  prod_t pnv_r  [3];
  prod_t pnt_r  [3];

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        pdet_r[i] <= PROD_W'(e1_2_r[i]) * PROD_W'(h[i]);
        pnu_r[i]  <= PROD_W'(s_2_r[i]) * PROD_W'(h[i]);
        pnv_r[i]  <= PROD_W'(dir[i]) * PROD_W'(q[i]);
        pnt_r[i]  <= PROD_W'(e2_2_r[i]) * PROD_W'(q[i]);
      end
    end
  end

  // stage 4: sums
  dot_t det4_r, nu4_r, nv4_r, nt4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      det4_r <= DOT_W'(pdet_r[0]) + DOT_W'(pdet_r[1]) + DOT_W'(pdet_r[2]);
      nu4_r  <= DOT_W'(pnu_r[0]) + DOT_W'(pnu_r[1]) + DOT_W'(pnu_r[2]);
      nv4_r  <= DOT_W'(pnv_r[0]) + DOT_W'(pnv_r[1]) + DOT_W'(pnv_r[2]);
      nt4_r  <= DOT_W'(pnt_r[0]) + DOT_W'(pnt_r[1]) + DOT_W'(pnt_r[2]);
    end
  end

  // stage 5: fold the sign so the determinant is non-negative
  dot_t det5_r, nu5_r, nv5_r, nt5_r;
  logic det_neg;

  assign det_neg = det4_r[DOT_W-1];

  always_ff @(posedge clk) begin
    if (en5) begin
      det5_r <= det_neg ? -det4_r : det4_r;
      nu5_r  <= det_neg ? -nu4_r  : nu4_r;
      nv5_r  <= det_neg ? -nv4_r  : nv4_r;
      nt5_r  <= det_neg ? -nt4_r  : nt4_r;
    end
  end

  // stage 6: ordered tests into the output register
  logic [MAG_W-1:0]        det_mag;
  logic [MAG_W-1:0]        thr_ext;
  logic signed [DOT_W:0]   uv_sum;
  logic signed [DOT_W:0]   det_ext;
  reason_t                 reason;
  out_item_t               out_data_r;
  out_item_t               out_data_nxt;

  assign det_mag = MAG_W'($unsigned(det5_r));
  assign thr_ext = MAG_W'(det_threshold_r);
  assign uv_sum  = (DOT_W + 1)'(nu5_r) + (DOT_W + 1)'(nv5_r);
  assign det_ext = (DOT_W + 1)'(det5_r);

  always_comb begin
    priority if (det5_r == '0 || det_mag < thr_ext) begin
      reason = REASON_PARALLEL;
    end else if (nu5_r < 0 || nu5_r > det5_r) begin
      reason = REASON_U_OUT;
    end else if (nv5_r < 0 || uv_sum > det_ext) begin
      reason = REASON_V_OUT;
    end else if (nt5_r < 0 || nt5_r > det5_r) begin
      reason = REASON_T_OUT;
    end else begin
      reason = REASON_HIT;
    end
    out_data_nxt.hit         = (reason == REASON_HIT);
    out_data_nxt.miss_reason = reason;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // in_stall only when every stage holds a transaction
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && v5_r && out_valid_r))
    else $error("input stalled with a bubble in the pipeline");

  // folded determinant is never negative
  a_det_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> !det5_r[DOT_W-1])
    else $error("negative determinant after sign fold");

  // zero determinant always reports parallel
  a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && en6 && det5_r == '0) |=>
      (out_data.miss_reason == REASON_PARALLEL && !out_data.hit))
    else $error("zero determinant not reported as parallel");
`endif

endmodule

### bench/segment_triangle_intersect_unit_tb.sv
// Self-checking testbench for the segment/triangle intersection unit.
module segment_triangle_intersect_unit_tb;
  import sti_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 147;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  in_item_t             in_data = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THRESH_W-1:0]  cfg_data = '0;
  wire                  in_stall;
  wire                  out_valid;
  wire                  cfg_ready;
  out_item_t            out_data;

  // Mirror of the configuration registers
  coord_t              seg_pt [6] = '{default: '0};
  logic [THRESH_W-1:0] det_floor = THRESH_RESET;

  out_item_t   crossings_due [$];
  int unsigned mismatches = 0;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  int unsigned sink_run = 0;
  bit          sink_block = 1'b0;

  segment_triangle_intersect_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // Exact Moller-Trumbore without division: numerators against the determinant.
  function automatic out_item_t predict_crossing(in_item_t t);
    longint    sp [3], ep [3], av [3], bv [3], cv [3];
    longint    dd [3], e1 [3], e2 [3], sv [3], h [3], q [3];
    longint    det, nu, nv, nt;
    reason_t   why;
    out_item_t r;
    av[0] = $signed(t.a_x); av[1] = $signed(t.a_y); av[2] = $signed(t.a_z);
    bv[0] = $signed(t.b_x); bv[1] = $signed(t.b_y); bv[2] = $signed(t.b_z);
    cv[0] = $signed(t.c_x); cv[1] = $signed(t.c_y); cv[2] = $signed(t.c_z);
    for (int i = 0; i < 3; i++) begin
      sp[i] = seg_pt[i];
      ep[i] = seg_pt[3 + i];
      dd[i] = ep[i] - sp[i];
      e1[i] = bv[i] - av[i];
      e2[i] = cv[i] - av[i];
      sv[i] = sp[i] - av[i];
    end
    h[0] = dd[1] * e2[2] - dd[2] * e2[1];
    h[1] = dd[2] * e2[0] - dd[0] * e2[2];
    h[2] = dd[0] * e2[1] - dd[1] * e2[0];
    q[0] = sv[1] * e1[2] - sv[2] * e1[1];
    q[1] = sv[2] * e1[0] - sv[0] * e1[2];
    q[2] = sv[0] * e1[1] - sv[1] * e1[0];
    det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    nu  = sv[0] * h[0] + sv[1] * h[1] + sv[2] * h[2];
    nv  = dd[0] * q[0] + dd[1] * q[1] + dd[2] * q[2];
    nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    // fold the sign so the determinant is non-negative
    if (det < 0) begin
      det = -det;
      nu  = -nu;
      nv  = -nv;
      nt  = -nt;
    end
    if (det == 0 || det < longint'({32'd0, det_floor}))
      why = REASON_PARALLEL;
    else if (nu < 0 || nu > det)
      why = REASON_U_OUT;
    else if (nv < 0 || nv > det - nu)
      why = REASON_V_OUT;
    else if (nt < 0 || nt > det)
      why = REASON_T_OUT;
    else
      why = REASON_HIT;
    r.hit         = (why == REASON_HIT);
    r.miss_reason = why;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        crossings_due.push_back(predict_crossing(in_data));
      if (out_valid && !out_stall) begin
        if (crossings_due.size() == 0) begin
          $error("result transaction with no triangle pending");
          mismatches++;
        end else begin
          want = crossings_due.pop_front();
          if (out_data.hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, out_data.hit);
            mismatches++;
          end
          if (out_data.miss_reason !== want.miss_reason) begin
            $error("miss_reason: expected %0d, got %0d", want.miss_reason,
                   out_data.miss_reason);
            mismatches++;
          end
        end
      end
    end
  end

  // Result side back-pressure: runs of stall and no stall, mostly short.
  always @(posedge clk) begin
    int unsigned r;
    if (sink_run == 0) begin
      r = $urandom_range(0, 99);
      sink_block = (r < 35) && !sink_quiet;
      sink_run = (r % 30 == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
    end else begin
      sink_run--;
    end
    out_stall <= sink_block;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (src_quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int rnd_sym(int unsigned rad);
    return int'($urandom_range(0, 2 * rad)) - int'(rad);
  endfunction

  function automatic in_item_t make_triangle(int ax, int ay, int az, int bx, int by,
                                             int bz, int cx, int cy, int cz);
    in_item_t t;
    t.a_x = coord_t'(ax); t.a_y = coord_t'(ay); t.a_z = coord_t'(az);
    t.b_x = coord_t'(bx); t.b_y = coord_t'(by); t.b_z = coord_t'(bz);
    t.c_x = coord_t'(cx); t.c_y = coord_t'(cy); t.c_z = coord_t'(cz);
    return t;
  endfunction

  task automatic send_triangle(in_item_t t);
    int unsigned gap;
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and let the pipeline empty before touching the registers.
  // Wait for a clock edge first so the last accepted transaction is already queued.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (crossings_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < REG_DET_THRESHOLD)
      seg_pt[idx] = coord_t'(data[COORD_WIDTH-1:0]);
    else if (idx == REG_DET_THRESHOLD)
      det_floor = data;
  endtask

  task automatic program_unit(int sx, int sy, int sz, int ex, int ey, int ez,
                              logic [THRESH_W-1:0] thr);
    logic [THRESH_W-1:0] junk [7];
    foreach (junk[i]) junk[i] = $urandom;
    wait_drained();
    // upper bits of coordinate writes carry noise; index 7 must be ignored
    write_reg(REG_UNUSED, junk[6]);
    write_reg(REG_SEG_START_X, {junk[0][31:16], coord_t'(sx)});
    write_reg(REG_SEG_START_Y, {junk[1][31:16], coord_t'(sy)});
    write_reg(REG_SEG_START_Z, {junk[2][31:16], coord_t'(sz)});
    write_reg(REG_SEG_END_X,   {junk[3][31:16], coord_t'(ex)});
    write_reg(REG_SEG_END_Y,   {junk[4][31:16], coord_t'(ey)});
    write_reg(REG_SEG_END_Z,   {junk[5][31:16], coord_t'(ez)});
    write_reg(REG_DET_THRESHOLD, thr);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_triangle();
    int       sp [3], dd [3], p [3], e1 [3], e2 [3], a [3], b [3], c [3];
    int       kt, ku, kv, rad, k;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      sp[i] = seg_pt[i];
      dd[i] = int'(seg_pt[3 + i]) - sp[i];
    end
    if (pick < 65) begin
      // triangle built around a point of the segment line
      kt = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 20)) - 6
                                       : int'($urandom_range(0, 8));
      case ($urandom_range(0, 3))
        0: rad = 8;
        1: rad = 256;
        2: rad = 2048;
        default: rad = 12000;
      endcase
      ku = $urandom_range(0, 16);
      kv = $urandom_range(0, 16 - ku);
      if ($urandom_range(0, 3) == 0) begin
        ku = int'($urandom_range(0, 24)) - 4;
        kv = int'($urandom_range(0, 24)) - 4;
      end
      for (int i = 0; i < 3; i++) begin
        e1[i] = rnd_sym(rad);
        e2[i] = rnd_sym(rad);
        p[i]  = sp[i] + (dd[i] * kt) / 8;
        a[i]  = p[i] - (ku * e1[i] + kv * e2[i]) / 16;
        b[i]  = a[i] + e1[i];
        c[i]  = a[i] + e2[i];
      end
    end else if (pick < 80) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = $urandom;
        b[i] = $urandom;
        c[i] = $urandom;
      end
    end else if (pick < 90) begin
      // one edge along the segment direction
      k = int'($urandom_range(0, 4)) - 2;
      for (int i = 0; i < 3; i++) begin
        a[i] = sp[i] + rnd_sym(4096);
        b[i] = a[i] + dd[i] * k;
        c[i] = sp[i] + rnd_sym(4096);
      end
    end else begin
      // collapsed triangle
      k = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        a[i] = sp[i] + rnd_sym(2048);
        b[i] = sp[i] + rnd_sym(2048);
        c[i] = sp[i] + rnd_sym(2048);
      end
      if (k == 0) b = a;
      else if (k == 1) c = a;
      else c = b;
    end
    send_triangle(make_triangle(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]));
  endtask

  // Reset leaves start equal to end, so every triangle is parallel.
  task automatic test_reset_defaults();
    send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_triangle(make_triangle(-512, -512, 0, 512, -512, 0, 0, 512, 0));
  endtask

  task automatic test_inside_boundaries();
    program_unit(0, 0, -256, 0, 0, 256, THRESH_RESET);
    send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_triangle(make_triangle(0, 0, 0, 0, 256, 0, 256, 0, 0));
    send_triangle(make_triangle(256, 256, 0, 256, -256, 0, -256, 256, 0));
    send_triangle(make_triangle(-256, -256, -256, 512, -256, -256, -256, 512, -256));
    send_triangle(make_triangle(-256, -256, 256, 512, -256, 256, -256, 512, 256));
  endtask

  task automatic test_miss_reasons();
    send_triangle(make_triangle(256, 0, 0, 256, 256, 0, 256, 0, 256));
    send_triangle(make_triangle(256, 0, 0, 512, 0, 0, 256, 256, 0));
    send_triangle(make_triangle(0, 256, 0, 256, 256, 0, 0, 512, 0));
    send_triangle(make_triangle(-256, -256, 0, 0, -256, 0, -256, 0, 0));
    send_triangle(make_triangle(-256, -256, 512, 512, -256, 512, -256, 512, 512));
    send_triangle(make_triangle(-256, -256, -512, 512, -256, -512, -256, 512, -512));
  endtask

  task automatic test_threshold_edge();
    program_unit(0, 0, 0, 0, 0, 1, THRESH_RESET);
    send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 167, 0));
    send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 168, 0));
    program_unit(0, 0, 0, 0, 0, 1, '0);
    send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 2, 0, 0));
  endtask

  task automatic test_extremes();
    program_unit(-32768, -32768, -32768, 32767, 32767, 32767, '1);
    send_triangle(make_triangle(-32768, -32768, -32768, 32767, 32767, 32767,
                                32767, -32768, 32767));
    send_triangle(make_triangle(32767, -32768, 0, -32768, 32767, 0, 0, 0, -32768));
    program_unit(-32768, -32768, -32768, 32767, 32767, 32767, '0);
    send_triangle(make_triangle(32767, -32768, 0, -32768, 32767, 0, 0, 0, -32768));
    send_triangle(make_triangle(-32768, 32767, -32768, 32767, -32768, 32767,
                                -32768, -32768, 32767));
  endtask

  task automatic test_random_segments();
    int                  s [3], e [3];
    logic [THRESH_W-1:0] thr;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int i = 0; i < 3; i++) begin
        if (ph == 5) begin
          s[i] = $urandom;
          e[i] = $urandom;
        end else begin
          s[i] = rnd_sym(4096);
          e[i] = (ph == 6) ? s[i] : s[i] + rnd_sym(($urandom_range(0, 1) != 0) ? 4096 : 64);
        end
      end
      case (ph % 5)
        0: thr = THRESH_RESET;
        1: thr = '0;
        2: thr = $urandom_range(0, 1 << 20);
        3: thr = $urandom;
        default: thr = '1;
      endcase
      program_unit(s[0], s[1], s[2], e[0], e[1], e[2], thr);
      // some phases run flat out with no idling on either side
      src_quiet  = (ph == 0 || ph == 4);
      sink_quiet = (ph == 0 || ph == 7);
      repeat (PHASE_ITEMS) send_random_triangle();
      src_quiet  = 1'b0;
      sink_quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_inside_boundaries();
    test_miss_reasons();
    test_threshold_edge();
    test_extremes();
    test_random_segments();
    wait_drained();
    if (mismatches == 0 && crossings_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### segment_triangle_intersect_unit.f
src/sti_pkg.sv
src/sti_xprod.sv
src/segment_triangle_intersect_unit.sv
bench/segment_triangle_intersect_unit_tb.sv
